### rtl/tkfv_pkg.sv
// Package for the top-k frequent values block: transaction payload types
// and fixed field widths. No dependencies.
package tkfv_pkg;

  localparam int ValueWidth    = 32;
  localparam int OutCountWidth = 16;
  localparam int TopKWidth     = 7;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic                         last;
  } in_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0]    value_res;
    logic        [OutCountWidth-1:0] count;
    logic                            final_result;
    logic                            overflow;
  } out_t;

endpackage

### rtl/top_k_frequent_values_core.sv
// Top level of the top-k frequent values block: counting table in two
// synchronous memories (one write and one read port each) plus a selection sequencer.
// Depends on tkfv_pkg.
//
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one signed value per
//   transaction; in_data.last marks the final element of a set. Output
//   channel (out_valid/out_stall/out_data) returns the report of a set.
//   cfg_we/cfg_data write top_k (0 acts as 1, above MAX_K acts as MAX_K).
// Operation:
//   Counting searches the table linearly, one entry at a time through the
//   registered read port (S_RD, then S_CMP per entry); the next item is
//   accepted only once this one is done. U is the number of distinct values
//   held so far (at most TABLE_DEPTH).
//   On a last item, each of the min(k, U) results needs a full scan of the
//   table, plus the S_EMIT state in which it is taken.
//   Results come out count first, ties to the larger value, descending.
// Reset: rst clears the table fill count, overflow flag, and sets top_k
//   to 1. The memories need no clearing; only filled entries are read.
// Stall: in_stall is high whenever an item is in progress. A result waits
//   in the output register while out_stall is high.
module top_k_frequent_values_core #(
  parameter int TABLE_DEPTH = 256,
  parameter int COUNT_WIDTH = 16,
  parameter int MAX_K       = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  tkfv_pkg::in_t                         in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output tkfv_pkg::out_t                        out_data,
  input  logic                                  cfg_we,
  input  logic [tkfv_pkg::TopKWidth-1:0]        cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW = AW + 1;
  localparam int KW = tkfv_pkg::TopKWidth;
  localparam int XW = (UW > KW) ? UW : KW;
  localparam logic [COUNT_WIDTH-1:0] CntMax = {COUNT_WIDTH{1'b1}};
  localparam logic [UW-1:0] DepthU = UW'(TABLE_DEPTH);
  localparam logic [KW-1:0] MaxK   = KW'(MAX_K);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_SRD  = 3'd4;
  localparam logic [2:0] S_SCMP = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [tkfv_pkg::ValueWidth-1:0] key_mem [TABLE_DEPTH];
  logic [COUNT_WIDTH-1:0]          cnt_mem [TABLE_DEPTH];

  logic [2:0]                      state;
  logic [KW-1:0]                   top_k;
  logic [UW-1:0]                   used;
  logic                            ovf;
  logic [AW-1:0]                   idx;
  logic signed [tkfv_pkg::ValueWidth-1:0] cur_val;
  logic                            cur_last;
  logic signed [tkfv_pkg::ValueWidth-1:0] key_q;
  logic [COUNT_WIDTH-1:0]          cnt_q;
  logic signed [tkfv_pkg::ValueWidth-1:0] best_key, prev_key;
  logic [COUNT_WIDTH-1:0]          best_cnt, prev_cnt;
  logic                            have;
  logic [KW-1:0]                   rank, k_lim;

  // memory write port
  logic                            mem_we;
  logic [AW-1:0]                   mem_waddr;
  logic [tkfv_pkg::ValueWidth-1:0] mem_wkey;
  logic [COUNT_WIDTH-1:0]          mem_wcnt;

  logic                            at_end, match, elig, take;
  logic signed [tkfv_pkg::ValueWidth-1:0] best_key_next;
  logic [COUNT_WIDTH-1:0]          best_cnt_next;
  logic [KW-1:0]                   k_clamp, k_sel;

  assign at_end = ({1'b0, idx} == used - UW'(1));
  assign match  = (key_q == cur_val);
  assign elig   = (rank == '0) || (prev_cnt > cnt_q) ||
                  ((prev_cnt == cnt_q) && (prev_key > key_q));
  assign take   = elig && (!have || (cnt_q > best_cnt) ||
                  ((cnt_q == best_cnt) && (key_q > best_key)));
  assign best_key_next = take ? key_q : best_key;
  assign best_cnt_next = take ? cnt_q : best_cnt;

  always_comb begin
    k_clamp = top_k;
    if (k_clamp == '0) k_clamp = KW'(1);
    if (k_clamp > MaxK) k_clamp = MaxK;
    k_sel = k_clamp;
    if (XW'(k_clamp) > XW'(used)) begin
      k_sel = KW'(used);
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx;
    mem_wkey  = cur_val;
    mem_wcnt  = cnt_q + COUNT_WIDTH'(1);
    case (state)
      S_CMP: begin
        mem_we = match && (cnt_q != CntMax);
      end
      S_INS: begin
        mem_we    = (used != DepthU);
        mem_waddr = AW'(used);
        mem_wcnt  = COUNT_WIDTH'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_waddr] <= mem_wkey;
      cnt_mem[mem_waddr] <= mem_wcnt;
    end
    key_q <= key_mem[idx];
    cnt_q <= cnt_mem[idx];
  end

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      top_k     <= KW'(1);
      used      <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
      have      <= 1'b0;
      rank      <= '0;
    end else begin
      if (cfg_we) top_k <= cfg_data;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_val  <= in_data.value;
            cur_last <= in_data.last;
            idx      <= '0;
            state    <= (used == '0) ? S_INS : S_RD;
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (match) begin
            if (cur_last) begin
              idx   <= '0;
              have  <= 1'b0;
              rank  <= '0;
              k_lim <= k_sel;
              state <= S_SRD;
            end else begin
              state <= S_IDLE;
            end
          end else if (at_end) begin
            state <= S_INS;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_RD;
          end
        end
        S_INS: begin
          if (used != DepthU) used <= used + UW'(1);
          else ovf <= 1'b1;
          idx <= '0;
          if (cur_last) begin
            have  <= 1'b0;
            rank  <= '0;
            // count the new entry when choosing k
            k_lim <= (used != DepthU && k_sel != k_clamp) ? k_sel + KW'(1) : k_sel;
            state <= S_SRD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_SRD: begin
          state <= S_SCMP;
        end
        S_SCMP: begin
          best_key <= best_key_next;
          best_cnt <= best_cnt_next;
          have     <= have | take;
          if (at_end) begin
            out_data.value_res    <= best_key_next;
            out_data.count        <= tkfv_pkg::OutCountWidth'(best_cnt_next);
            out_data.final_result <= (rank + KW'(1) == k_lim);
            out_data.overflow     <= ovf;
            out_valid             <= 1'b1;
            prev_key              <= best_key_next;
            prev_cnt              <= best_cnt_next;
            state                 <= S_EMIT;
          end else begin
            idx   <= idx + AW'(1);
            state <= S_SRD;
          end
        end
        S_EMIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            rank      <= rank + KW'(1);
            idx       <= '0;
            have      <= 1'b0;
            if (rank + KW'(1) == k_lim) begin
              used  <= '0;
              ovf   <= 1'b0;
              state <= S_IDLE;
            end else begin
              state <= S_SRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Assertions
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= DepthU) else $error("fill count beyond table depth");

  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result pending");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && out_data.final_result) |=>
      (used == '0 && !ovf && !out_valid))
    else $error("table not cleared after final result");

  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rank < k_lim)) else $error("more results than k");

endmodule
